// ===== hw/rtl/gdvfs_pkg.sv =====
package gdvfs_pkg;

	// profile table geometry
	localparam int PROFILE_COUNT = 8;
	localparam int IDX_W         = (PROFILE_COUNT > 1) ? $clog2(PROFILE_COUNT) : 1;
	localparam int PROF_W        = 3;
	localparam int TOP_PROFILE   = (PROFILE_COUNT < 8) ? PROFILE_COUNT - 1 : 7;

	// field widths
	localparam int FREQ_W = 24;
	localparam int PCT_W  = 7;
	localparam int RUN_W  = 8;
	localparam int CNT_W  = 32;
	localparam int TEMP_W = 16;
	localparam int PER_W  = 10;
	localparam int CFG_W  = 16;
	localparam int CIDX_W = 3;

	// threshold arithmetic widths
	localparam int FP_W  = FREQ_W + PER_W;
	localparam int TH_W  = FP_W + PCT_W;
	localparam int REF_W = CNT_W + 8;

	localparam logic [PCT_W-1:0] PCT_DIV = PCT_W'(100);

	// configuration register indexes
	typedef logic [CIDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MIN_PROFILE  = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_MAX_PROFILE  = cfg_idx_t'(1);
	localparam cfg_idx_t CFG_SAFE_PROFILE = cfg_idx_t'(2);
	localparam cfg_idx_t CFG_TEMP_HIGH    = cfg_idx_t'(3);
	localparam cfg_idx_t CFG_TEMP_LOW     = cfg_idx_t'(4);
	localparam cfg_idx_t CFG_PERIOD_MS    = cfg_idx_t'(5);

	// input item kinds
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_PERIOD = 1'b1;

	// one profile table entry
	typedef struct packed {
		logic [RUN_W-1:0]  down_runs;
		logic [RUN_W-1:0]  up_runs;
		logic [PCT_W-1:0]  down_pct;
		logic [PCT_W-1:0]  up_pct;
		logic [FREQ_W-1:0] freq;
	} entry_t;

	// table write port
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

	// governor sequencer
	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_DEC
	} gov_state_t;

endpackage

// ===== hw/rtl/gdvfs_chan_if.sv =====
// input item channel
interface gdvfs_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 kind;
	logic [2:0]                           entry_index;
	logic [gdvfs_pkg::FREQ_W-1:0]         entry_freq;
	logic [gdvfs_pkg::PCT_W-1:0]          entry_up_percent;
	logic [gdvfs_pkg::PCT_W-1:0]          entry_down_percent;
	logic [gdvfs_pkg::RUN_W-1:0]          entry_up_runs;
	logic [gdvfs_pkg::RUN_W-1:0]          entry_down_runs;
	logic [gdvfs_pkg::CNT_W-1:0]          busy_count;
	logic [gdvfs_pkg::TEMP_W-1:0]         temperature;

	modport source (
		output valid, kind, entry_index, entry_freq, entry_up_percent,
		       entry_down_percent, entry_up_runs, entry_down_runs,
		       busy_count, temperature,
		input  ready
	);
	modport sink (
		input  valid, kind, entry_index, entry_freq, entry_up_percent,
		       entry_down_percent, entry_up_runs, entry_down_runs,
		       busy_count, temperature,
		output ready
	);
endinterface

// result item channel
interface gdvfs_out_if;
	logic                          valid;
	logic                          ready;
	logic [gdvfs_pkg::PROF_W-1:0]  profile;
	logic                          changed;
	logic                          raised;
	logic                          thermal_cap;

	modport source (
		output valid, profile, changed, raised, thermal_cap,
		input  ready
	);
	modport sink (
		input  valid, profile, changed, raised, thermal_cap,
		output ready
	);
endinterface

// ===== hw/rtl/gdvfs_table.sv =====
module gdvfs_table (
	input  logic                          clk,
	input  gdvfs_pkg::tbl_wr_t            wr,
	input  logic                          rd_en,
	input  logic [gdvfs_pkg::IDX_W-1:0]   rd_addr,
	output gdvfs_pkg::entry_t             rd_data
);

	gdvfs_pkg::entry_t mem [gdvfs_pkg::PROFILE_COUNT];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/gpu_dvfs_profile_governor.sv =====
// period item: table read, freq*period, *percent, then decision; the input is not
// ready until the decision is made, and the decision waits while the output is stalled
// load item: written to the profile table at the accept edge, 1 item per cycle while
// idle; a finished result sits in an output register, and the next item can be taken then
// reset: profile 0, run counters and thermal flag cleared, config registers at
// their reset values; the profile table is undefined until loaded
module gpu_dvfs_profile_governor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gdvfs_pkg::CIDX_W-1:0]      cfg_index,
	input  logic [gdvfs_pkg::CFG_W-1:0]       cfg_data,
	gdvfs_in_if.sink                          item_in,
	gdvfs_out_if.source                       item_out
);

	localparam logic [gdvfs_pkg::PROF_W-1:0] TOP =
		gdvfs_pkg::PROF_W'(gdvfs_pkg::TOP_PROFILE);
	localparam logic [gdvfs_pkg::RUN_W-1:0] RUN_MAX = '1;

	// configuration registers
	logic [gdvfs_pkg::PROF_W-1:0] min_profile_q, max_profile_q, safe_profile_q;
	logic [gdvfs_pkg::TEMP_W-1:0] temp_high_q, temp_low_q;
	logic [gdvfs_pkg::PER_W-1:0]  period_ms_q;

	// governor state
	gdvfs_pkg::gov_state_t        state_q, state_d;
	logic [gdvfs_pkg::PROF_W-1:0] cur_q;
	logic [gdvfs_pkg::RUN_W-1:0]  up_run_q, down_run_q;
	logic                         therm_q;

	// pipeline
	logic [gdvfs_pkg::CNT_W-1:0]  count_s1;
	logic [gdvfs_pkg::TEMP_W-1:0] temp_s1;
	logic [gdvfs_pkg::FP_W-1:0]   fp_s2;
	logic [gdvfs_pkg::PCT_W-1:0]  up_pct_s2, dn_pct_s2;
	logic [gdvfs_pkg::RUN_W-1:0]  up_need_s2, dn_need_s2;
	logic [gdvfs_pkg::REF_W-1:0]  hi_ref_s2, lo_ref_s2;
	logic [gdvfs_pkg::TH_W-1:0]   up_th_s3, dn_th_s3;

	// output register
	logic                         out_valid_q;
	logic [gdvfs_pkg::PROF_W-1:0] out_profile_q;
	logic                         out_changed_q, out_raised_q, out_therm_q;

	// control
	logic                         in_acc, rd_en, dec_go;
	gdvfs_pkg::tbl_wr_t           tbl_wr;
	gdvfs_pkg::entry_t            tbl_rd;

	// decision
	logic [gdvfs_pkg::CNT_W:0]    cnt_p1;
	logic [gdvfs_pkg::REF_W-1:0]  hi_ref, lo_ref;
	logic                         is_low, is_high, therm_d;
	logic [gdvfs_pkg::RUN_W-1:0]  up_run_d, down_run_d;
	logic [gdvfs_pkg::PROF_W-1:0] target, clamped, capped, final_prof;

	gdvfs_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_en   (rd_en),
		.rd_addr (gdvfs_pkg::IDX_W'(cur_q)),
		.rd_data (tbl_rd)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_profile_q  <= '0;
			max_profile_q  <= gdvfs_pkg::PROF_W'(7);
			safe_profile_q <= '0;
			temp_high_q    <= '1;
			temp_low_q     <= '0;
			period_ms_q    <= gdvfs_pkg::PER_W'(50);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gdvfs_pkg::CFG_MIN_PROFILE:  min_profile_q  <= cfg_data[gdvfs_pkg::PROF_W-1:0];
				gdvfs_pkg::CFG_MAX_PROFILE:  max_profile_q  <= cfg_data[gdvfs_pkg::PROF_W-1:0];
				gdvfs_pkg::CFG_SAFE_PROFILE: safe_profile_q <= cfg_data[gdvfs_pkg::PROF_W-1:0];
				gdvfs_pkg::CFG_TEMP_HIGH:    temp_high_q    <= cfg_data[gdvfs_pkg::TEMP_W-1:0];
				gdvfs_pkg::CFG_TEMP_LOW:     temp_low_q     <= cfg_data[gdvfs_pkg::TEMP_W-1:0];
				gdvfs_pkg::CFG_PERIOD_MS:    period_ms_q    <= cfg_data[gdvfs_pkg::PER_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gdvfs_pkg::S_IDLE: if (in_acc && item_in.kind == gdvfs_pkg::KIND_PERIOD) begin
				state_d = gdvfs_pkg::S_MUL1;
			end
			gdvfs_pkg::S_MUL1: state_d = gdvfs_pkg::S_MUL2;
			gdvfs_pkg::S_MUL2: state_d = gdvfs_pkg::S_DEC;
			gdvfs_pkg::S_DEC: if (dec_go) begin
				state_d = gdvfs_pkg::S_IDLE;
			end
			default: state_d = gdvfs_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_in.ready = (state_q == gdvfs_pkg::S_IDLE);
		in_acc        = item_in.valid && item_in.ready;
		rd_en         = in_acc && item_in.kind == gdvfs_pkg::KIND_PERIOD;
		dec_go        = (state_q == gdvfs_pkg::S_DEC) && (!out_valid_q || item_out.ready);
		tbl_wr.en     = in_acc && item_in.kind == gdvfs_pkg::KIND_LOAD
			&& int'(item_in.entry_index) < gdvfs_pkg::PROFILE_COUNT;
		tbl_wr.addr   = gdvfs_pkg::IDX_W'(item_in.entry_index);
		tbl_wr.data.freq      = item_in.entry_freq;
		tbl_wr.data.up_pct    = item_in.entry_up_percent;
		tbl_wr.data.down_pct  = item_in.entry_down_percent;
		tbl_wr.data.up_runs   = item_in.entry_up_runs;
		tbl_wr.data.down_runs = item_in.entry_down_runs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdvfs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// busy count scaled by 100: count > floor(p/100) iff 100*count > p,
	// count < floor(p/100) iff 100*(count+1) <= p
	always_comb begin
		cnt_p1 = {1'b0, count_s1} + (gdvfs_pkg::CNT_W+1)'(1);
		hi_ref = (gdvfs_pkg::REF_W'(count_s1) << 6) + (gdvfs_pkg::REF_W'(count_s1) << 5)
			+ (gdvfs_pkg::REF_W'(count_s1) << 2);
		lo_ref = (gdvfs_pkg::REF_W'(cnt_p1) << 6) + (gdvfs_pkg::REF_W'(cnt_p1) << 5)
			+ (gdvfs_pkg::REF_W'(cnt_p1) << 2);
	end

	// pipeline: capture, freq*period, *percent
	always_ff @(posedge clk) begin
		if (rd_en) begin
			count_s1 <= item_in.busy_count;
			temp_s1  <= item_in.temperature;
		end
		if (state_q == gdvfs_pkg::S_MUL1) begin
			fp_s2      <= gdvfs_pkg::FP_W'(tbl_rd.freq) * gdvfs_pkg::FP_W'(period_ms_q);
			up_pct_s2  <= tbl_rd.up_pct;
			dn_pct_s2  <= tbl_rd.down_pct;
			up_need_s2 <= tbl_rd.up_runs;
			dn_need_s2 <= tbl_rd.down_runs;
			hi_ref_s2  <= hi_ref;
			lo_ref_s2  <= lo_ref;
		end
		if (state_q == gdvfs_pkg::S_MUL2) begin
			up_th_s3 <= gdvfs_pkg::TH_W'(fp_s2) * gdvfs_pkg::TH_W'(up_pct_s2);
			dn_th_s3 <= gdvfs_pkg::TH_W'(fp_s2) * gdvfs_pkg::TH_W'(dn_pct_s2);
		end
	end

	// run counters and step target
	always_comb begin
		is_low     = (gdvfs_pkg::TH_W'(lo_ref_s2) <= dn_th_s3) && (cur_q != '0);
		is_high    = (gdvfs_pkg::TH_W'(hi_ref_s2) > up_th_s3) && (cur_q < TOP);
		up_run_d   = '0;
		down_run_d = '0;
		target     = cur_q;
		priority if (is_low) begin
			down_run_d = (down_run_q == RUN_MAX) ? RUN_MAX : down_run_q + 1'b1;
			if (down_run_d >= dn_need_s2) begin
				target     = cur_q - 1'b1;
				down_run_d = '0;
			end
		end else if (is_high) begin
			up_run_d = (up_run_q == RUN_MAX) ? RUN_MAX : up_run_q + 1'b1;
			if (up_run_d >= up_need_s2 && up_pct_s2 < gdvfs_pkg::PCT_DIV) begin
				target   = cur_q + 1'b1;
				up_run_d = '0;
			end
		end else begin
			// other period: both runs clear
			up_run_d   = '0;
			down_run_d = '0;
		end
	end

	// min/max clamp, thermal hysteresis and cap
	always_comb begin
		priority if (target < min_profile_q) begin
			clamped = min_profile_q;
		end else if (target > max_profile_q) begin
			clamped = max_profile_q;
		end else begin
			clamped = target;
		end
		priority if (temp_s1 > temp_high_q) begin
			therm_d = 1'b1;
		end else if (temp_s1 < temp_low_q) begin
			therm_d = 1'b0;
		end else begin
			therm_d = therm_q;
		end
		capped     = (therm_d && clamped > safe_profile_q) ? safe_profile_q : clamped;
		final_prof = (capped > TOP) ? TOP : capped;
	end

	// governor state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= '0;
			up_run_q   <= '0;
			down_run_q <= '0;
			therm_q    <= 1'b0;
		end else if (dec_go) begin
			cur_q      <= final_prof;
			up_run_q   <= up_run_d;
			down_run_q <= down_run_d;
			therm_q    <= therm_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dec_go) begin
			out_valid_q <= 1'b1;
		end else if (item_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_go) begin
			out_profile_q <= final_prof;
			out_changed_q <= (final_prof != cur_q);
			out_raised_q  <= (final_prof > cur_q);
			out_therm_q   <= therm_d;
		end
	end

	assign item_out.valid       = out_valid_q;
	assign item_out.profile     = out_profile_q;
	assign item_out.changed     = out_changed_q;
	assign item_out.raised      = out_raised_q;
	assign item_out.thermal_cap = out_therm_q;

	// checks
	a_cur_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= TOP)
		else $error("current profile above top profile");

	a_runs_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(up_run_q != '0 && down_run_q != '0))
		else $error("up and down runs both nonzero");

	a_result_follows_dec: assert property (@(posedge clk) disable iff (!arst_n)
		dec_go |=> item_out.valid && item_out.profile == cur_q
			&& item_out.changed == (cur_q != $past(cur_q)))
		else $error("result does not match updated profile");

	a_raised_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid && item_out.raised |-> item_out.changed)
		else $error("raised without change");

	a_thermal_caps: assert property (@(posedge clk) disable iff (!arst_n)
		dec_go && therm_d |=> cur_q <= $past(safe_profile_q))
		else $error("thermal cap not applied");

endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import gdvfs_pkg::*;

	// one input item, every field present whatever the kind
	typedef struct packed {
		bit                kind;
		bit [2:0]          idx;
		bit [FREQ_W-1:0]   freq;
		bit [PCT_W-1:0]    up_pct;
		bit [PCT_W-1:0]    dn_pct;
		bit [RUN_W-1:0]    up_runs;
		bit [RUN_W-1:0]    dn_runs;
		bit [CNT_W-1:0]    busy;
		bit [TEMP_W-1:0]   temp;
	} gov_item_t;

	// one profile decision
	typedef struct packed {
		bit [PROF_W-1:0] profile;
		bit              changed;
		bit              raised;
		bit              hot;
	} decision_t;

	// directed stimulus row: a register write or an item
	typedef struct {
		bit         is_cfg;
		cfg_idx_t   reg_idx;
		int unsigned reg_val;
		gov_item_t  it;
		bit         typed;
		decision_t  want;
	} dir_row_t;

	localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	cfg_idx_t          cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	gdvfs_in_if  in_ch();
	gdvfs_out_if out_ch();

	gpu_dvfs_profile_governor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_in   (in_ch),
		.item_out  (out_ch)
	);

	always #5 clk = ~clk;

	// governor registers as last written
	int unsigned cfg_min = 0;
	int unsigned cfg_max = 7;
	int unsigned cfg_safe = 0;
	int unsigned cfg_thi = 65535;
	int unsigned cfg_tlo = 0;
	int unsigned cfg_period = 50;

	// governor state after the last accepted item
	int unsigned pred_cur = 0;
	int unsigned pred_up_run = 0;
	int unsigned pred_dn_run = 0;
	bit          pred_hot = 1'b0;
	entry_t      tbl [PROFILE_COUNT];

	decision_t profile_due [$];
	int        fail_count = 0;
	int        send_idle_pct = 20;
	bit        valid_up = 1'b0;

	// busy threshold of one profile at the current period length
	function automatic longint unsigned scaled_threshold(input int unsigned prof,
			input bit use_up);
		entry_t          e;
		longint unsigned pct;
		e = tbl[prof];
		pct = use_up ? 64'(e.up_pct) : 64'(e.down_pct);
		return 64'(e.freq) * 64'(cfg_period) * pct / 64'(PCT_DIV);
	endfunction

	// apply one item to the governor state, returns 1 when it yields a decision
	function automatic bit step_governor(input gov_item_t it, output decision_t d);
		entry_t          e;
		longint unsigned up_th;
		longint unsigned dn_th;
		int unsigned     cur;
		int unsigned     tgt;
		d = '0;
		if (it.kind == KIND_LOAD) begin
			if (int'(it.idx) < PROFILE_COUNT) begin
				e.freq = it.freq;
				e.up_pct = it.up_pct;
				e.down_pct = it.dn_pct;
				e.up_runs = it.up_runs;
				e.down_runs = it.dn_runs;
				tbl[it.idx] = e;
			end
			return 1'b0;
		end
		cur = pred_cur;
		e = tbl[cur];
		up_th = scaled_threshold(cur, 1'b1);
		dn_th = scaled_threshold(cur, 1'b0);
		tgt = cur;
		// run counting and stepping
		if (64'(it.busy) < dn_th && cur > 0) begin
			pred_dn_run = (pred_dn_run >= 255) ? 255 : pred_dn_run + 1;
			pred_up_run = 0;
			if (pred_dn_run >= e.down_runs) begin
				tgt = cur - 1;
				pred_dn_run = 0;
			end
		end else if (64'(it.busy) > up_th && cur < TOP_PROFILE) begin
			pred_dn_run = 0;
			pred_up_run = (pred_up_run >= 255) ? 255 : pred_up_run + 1;
			if (pred_up_run >= e.up_runs && e.up_pct < PCT_DIV) begin
				tgt = cur + 1;
				pred_up_run = 0;
			end
		end else begin
			pred_up_run = 0;
			pred_dn_run = 0;
		end
		// min/max clamp, min wins when above max
		if (tgt < cfg_min)
			tgt = cfg_min;
		else if (tgt > cfg_max)
			tgt = cfg_max;
		// thermal hysteresis and cap
		if (it.temp > cfg_thi)
			pred_hot = 1'b1;
		else if (it.temp < cfg_tlo)
			pred_hot = 1'b0;
		if (pred_hot && tgt > cfg_safe)
			tgt = cfg_safe;
		if (tgt > TOP_PROFILE)
			tgt = TOP_PROFILE;
		d.profile = 3'(tgt);
		d.changed = (tgt != cur);
		d.raised = (tgt > cur);
		d.hot = pred_hot;
		pred_cur = tgt;
		return 1'b1;
	endfunction

	// idle length: mostly short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(16, 60);
	endfunction

	function automatic gov_item_t random_item();
		gov_item_t it;
		it.kind = $urandom_range(0, 1);
		it.idx = $urandom;
		it.freq = $urandom;
		it.up_pct = $urandom;
		it.dn_pct = $urandom;
		it.up_runs = $urandom;
		it.dn_runs = $urandom;
		it.busy = $urandom;
		it.temp = $urandom;
		return it;
	endfunction

	// table entry load with plausible policy most of the time
	function automatic gov_item_t random_load();
		gov_item_t it;
		int        r;
		it = random_item();
		it.kind = KIND_LOAD;
		r = $urandom_range(0, 99);
		if (r < 8)
			it.freq = '1;
		else if (r < 12)
			it.freq = '0;
		else
			it.freq = FREQ_W'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 14));
		if ($urandom_range(0, 99) < 88) begin
			it.up_pct = $urandom_range(40, 100);
			it.dn_pct = $urandom_range(0, 60);
		end else begin
			it.up_pct = $urandom_range(0, 127);
			it.dn_pct = $urandom_range(0, 127);
		end
		r = $urandom_range(0, 99);
		it.up_runs = (r < 70) ? $urandom_range(0, 3) : (r < 85) ? $urandom_range(4, 20) :
			(r < 93) ? 255 : $urandom_range(0, 255);
		r = $urandom_range(0, 99);
		it.dn_runs = (r < 70) ? $urandom_range(0, 3) : (r < 85) ? $urandom_range(4, 20) :
			(r < 93) ? 255 : $urandom_range(0, 255);
		return it;
	endfunction

	// busy count placed around the thresholds of the current profile
	function automatic bit [31:0] pick_busy();
		longint unsigned up_th;
		longint unsigned dn_th;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned v;
		int              r;
		up_th = scaled_threshold(pred_cur, 1'b1);
		dn_th = scaled_threshold(pred_cur, 1'b0);
		r = $urandom_range(0, 99);
		if (r < 30) begin
			hi = (dn_th == 0) ? 0 : dn_th - 1;
			if (hi > CNT_MAX)
				hi = CNT_MAX;
			v = (r < 15) ? hi : 64'({$urandom, $urandom}) % (hi + 1);
		end else if (r < 60) begin
			lo = up_th + 1;
			if (lo > CNT_MAX)
				lo = CNT_MAX;
			v = (r < 45) ? lo : lo + 64'({$urandom, $urandom}) % (CNT_MAX - lo + 1);
		end else if (r < 75) begin
			lo = (dn_th < up_th) ? dn_th : up_th;
			hi = (dn_th < up_th) ? up_th : dn_th;
			if (lo > CNT_MAX)
				lo = CNT_MAX;
			if (hi > CNT_MAX)
				hi = CNT_MAX;
			v = lo + 64'({$urandom, $urandom}) % (hi - lo + 1);
		end else if (r < 88) begin
			v = r[0] ? dn_th : up_th;
		end else begin
			v = $urandom;
		end
		if (v > CNT_MAX)
			v = CNT_MAX;
		return v[31:0];
	endfunction

	// temperature near the hysteresis edges, sometimes anywhere
	function automatic bit [15:0] pick_temp();
		int v;
		if ($urandom_range(0, 99) < 30)
			return 16'($urandom);
		v = ($urandom_range(0, 1) ? int'(cfg_thi) : int'(cfg_tlo)) +
			int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	function automatic dir_row_t load_row(input int unsigned idx, input int unsigned freq,
			input int unsigned up, input int unsigned dn, input int unsigned ur,
			input int unsigned dr);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = CFG_MIN_PROFILE;
		row.reg_val = 0;
		row.it = '0;
		row.it.kind = KIND_LOAD;
		row.it.idx = idx;
		row.it.freq = freq;
		row.it.up_pct = up;
		row.it.dn_pct = dn;
		row.it.up_runs = ur;
		row.it.dn_runs = dr;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	function automatic dir_row_t period_row(input int unsigned busy, input int unsigned temp,
			input bit typed, input int unsigned prof, input bit chg, input bit rse,
			input bit hot);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = CFG_MIN_PROFILE;
		row.reg_val = 0;
		row.it = '0;
		row.it.kind = KIND_PERIOD;
		row.it.busy = busy;
		row.it.temp = temp;
		row.typed = typed;
		row.want.profile = prof;
		row.want.changed = chg;
		row.want.raised = rse;
		row.want.hot = hot;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input cfg_idx_t idx, input int unsigned val);
		dir_row_t row;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		row.it = '0;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	// drop valid if it is up
	task automatic idle_input();
		if (valid_up) begin
			in_ch.valid <= 1'b0;
			valid_up = 1'b0;
		end
	endtask

	// offer one item, wait for acceptance, then record its decision
	task automatic offer(input gov_item_t it, input bit typed, input decision_t want);
		int        gap;
		bit        has;
		decision_t got;
		gap = ($urandom_range(0, 99) < send_idle_pct) ? gap_len() : 0;
		if (gap > 0) begin
			idle_input();
			repeat (gap) @(posedge clk);
		end
		in_ch.kind <= it.kind;
		in_ch.entry_index <= it.idx;
		in_ch.entry_freq <= it.freq;
		in_ch.entry_up_percent <= it.up_pct;
		in_ch.entry_down_percent <= it.dn_pct;
		in_ch.entry_up_runs <= it.up_runs;
		in_ch.entry_down_runs <= it.dn_runs;
		in_ch.busy_count <= it.busy;
		in_ch.temperature <= it.temp;
		in_ch.valid <= 1'b1;
		valid_up = 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		has = step_governor(it, got);
		if (has)
			profile_due.push_back(typed ? want : got);
	endtask

	// register write once the governor has drained
	task automatic set_reg(input cfg_idx_t idx, input int unsigned val);
		idle_input();
		while (profile_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MIN_PROFILE:  cfg_min = val & 7;
			CFG_MAX_PROFILE:  cfg_max = val & 7;
			CFG_SAFE_PROFILE: cfg_safe = val & 7;
			CFG_TEMP_HIGH:    cfg_thi = val & 16'hFFFF;
			CFG_TEMP_LOW:     cfg_tlo = val & 16'hFFFF;
			CFG_PERIOD_MS:    cfg_period = val & 10'h3FF;
			default: ;
		endcase
	endtask

	// stimulus
	initial begin : stimulus
		gov_item_t   it;
		dir_row_t    dir_rows [$];
		int unsigned s_min;
		int unsigned s_max;
		int unsigned s_safe;
		int unsigned s_thi;
		int unsigned s_tlo;
		int unsigned s_per;
		int unsigned tmp;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MIN_PROFILE;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= KIND_LOAD;
		in_ch.entry_index <= '0;
		in_ch.entry_freq <= '0;
		in_ch.entry_up_percent <= '0;
		in_ch.entry_down_percent <= '0;
		in_ch.entry_up_runs <= '0;
		in_ch.entry_down_runs <= '0;
		in_ch.busy_count <= '0;
		in_ch.temperature <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whole table loaded before any period reads it
		dir_rows.push_back(load_row(0, 1000, 80, 20, 1, 1));
		dir_rows.push_back(load_row(1, 2000, 80, 20, 1, 1));
		dir_rows.push_back(load_row(2, 24'hFFFFFF, 100, 0, 0, 0));
		dir_rows.push_back(load_row(3, 0, 0, 0, 0, 0));
		dir_rows.push_back(load_row(4, 4000, 127, 101, 255, 255));
		dir_rows.push_back(load_row(5, 5000, 70, 30, 2, 2));
		dir_rows.push_back(load_row(6, 6000, 70, 30, 2, 2));
		dir_rows.push_back(load_row(7, 7000, 70, 30, 255, 0));
		// quiet period right after reset, then full-scale busy steps up
		dir_rows.push_back(period_row(0, 0, 1, 0, 0, 0, 0));
		dir_rows.push_back(period_row(32'hFFFFFFFF, 65535, 1, 1, 1, 1, 0));
		dir_rows.push_back(period_row(32'hFFFFFFFF, 0, 1, 2, 1, 1, 0));
		// up percent of 100 holds the profile
		dir_rows.push_back(period_row(32'hFFFFFFFF, 0, 1, 2, 0, 0, 0));
		dir_rows.push_back(period_row(0, 0, 0, 0, 0, 0, 0));
		// zero period length gives zero thresholds
		dir_rows.push_back(cfg_row(CFG_PERIOD_MS, 0));
		dir_rows.push_back(load_row(2, 24'hFFFFFF, 50, 0, 0, 0));
		dir_rows.push_back(period_row(1, 0, 0, 0, 0, 0, 0));
		// thermal limiting sets, holds in the band, then clears
		dir_rows.push_back(cfg_row(CFG_PERIOD_MS, 1023));
		dir_rows.push_back(cfg_row(CFG_TEMP_HIGH, 1000));
		dir_rows.push_back(cfg_row(CFG_TEMP_LOW, 500));
		dir_rows.push_back(cfg_row(CFG_SAFE_PROFILE, 1));
		dir_rows.push_back(period_row(0, 1001, 1, 1, 1, 0, 1));
		dir_rows.push_back(period_row(0, 700, 0, 0, 0, 0, 0));
		dir_rows.push_back(period_row(32'hFFFFFFFF, 499, 0, 0, 0, 0, 0));
		// min above max lifts to min
		dir_rows.push_back(cfg_row(CFG_MIN_PROFILE, 7));
		dir_rows.push_back(cfg_row(CFG_MAX_PROFILE, 0));
		dir_rows.push_back(period_row(0, 0, 1, 7, 1, 1, 0));
		dir_rows.push_back(period_row(32'hFFFFFFFF, 0, 0, 0, 0, 0, 0));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				set_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			else
				offer(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin
					s_min = 0; s_max = 7; s_safe = 0; s_thi = 65535; s_tlo = 0; s_per = 50;
				end
				1: begin
					s_min = 0; s_max = 7; s_safe = 7; s_thi = 65535; s_tlo = 65535;
					s_per = 1000;
				end
				2: begin
					s_min = 6; s_max = 2; s_safe = 3; s_thi = 0; s_tlo = 0; s_per = 1;
				end
				3: begin
					s_min = 4; s_max = 4; s_safe = 7; s_thi = 40000; s_tlo = 20000; s_per = 0;
				end
				default: begin
					s_min = $urandom_range(0, 3);
					s_max = $urandom_range(3, 7);
					if ($urandom_range(0, 4) == 0) begin
						tmp = s_min;
						s_min = s_max;
						s_max = tmp;
					end
					s_safe = $urandom_range(0, 7);
					s_thi = $urandom_range(0, 65535);
					s_tlo = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) :
						$urandom_range(0, s_thi);
					case ($urandom_range(0, 9))
						0: s_per = 1023;
						1: s_per = 1;
						2: s_per = 1000;
						default: s_per = $urandom_range(1, 1000);
					endcase
				end
			endcase
			set_reg(CFG_MIN_PROFILE, s_min);
			set_reg(CFG_MAX_PROFILE, s_max);
			set_reg(CFG_SAFE_PROFILE, s_safe);
			set_reg(CFG_TEMP_HIGH, s_thi);
			set_reg(CFG_TEMP_LOW, s_tlo);
			set_reg(CFG_PERIOD_MS, s_per);
			case (ph % 3)
				0: send_idle_pct = 0;
				1: send_idle_pct = 20;
				default: send_idle_pct = 60;
			endcase
			repeat (90) begin
				if ($urandom_range(0, 99) < 12) begin
					it = random_load();
				end else begin
					it = random_item();
					it.kind = KIND_PERIOD;
					it.busy = pick_busy();
					it.temp = pick_temp();
				end
				offer(it, 1'b0, '0);
			end
		end

		// run counter saturation: long blocked high run, then a need of 255
		send_idle_pct = 20;
		set_reg(CFG_MIN_PROFILE, 0);
		set_reg(CFG_MAX_PROFILE, 6);
		set_reg(CFG_SAFE_PROFILE, 0);
		set_reg(CFG_TEMP_HIGH, 65535);
		set_reg(CFG_TEMP_LOW, 65535);
		set_reg(CFG_PERIOD_MS, 50);
		it = random_item();
		it.kind = KIND_PERIOD;
		it.busy = 0;
		it.temp = 0;
		offer(it, 1'b0, '0);
		set_reg(CFG_MAX_PROFILE, 7);
		it = random_load();
		it.idx = pred_cur;
		it.freq = 1000;
		it.up_pct = 100;
		it.dn_pct = 0;
		it.up_runs = 0;
		it.dn_runs = 0;
		offer(it, 1'b0, '0);
		repeat (300) begin
			it = random_item();
			it.kind = KIND_PERIOD;
			it.busy = '1;
			it.temp = $urandom_range(0, 65534);
			offer(it, 1'b0, '0);
		end
		it = random_load();
		it.idx = pred_cur;
		it.freq = 1000;
		it.up_pct = 50;
		it.dn_pct = 0;
		it.up_runs = 255;
		it.dn_runs = 0;
		offer(it, 1'b0, '0);
		repeat (4) begin
			it = random_item();
			it.kind = KIND_PERIOD;
			it.busy = '1;
			it.temp = $urandom_range(0, 65534);
			offer(it, 1'b0, '0);
		end

		// drain and report
		idle_input();
		for (int w = 0; w < 5000 && profile_due.size() != 0; w++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && profile_due.size() == 0) begin
			$display("status: pass");
		end else begin
			if (profile_due.size() != 0)
				$display("%0d decisions never arrived", profile_due.size());
			$display("status: fail");
		end
		$finish;
	end

	// result side: random back-pressure, one long hold-off, and checking
	initial begin : result_sink
		int        stall_left;
		int        stretch;
		int        idle_pct;
		int        results_seen;
		bit        held_off;
		decision_t want;
		stall_left = 0;
		stretch = 0;
		idle_pct = 0;
		results_seen = 0;
		held_off = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				results_seen++;
				if (profile_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected decision: profile %0d changed %0d raised %0d cap %0d",
							out_ch.profile, out_ch.changed, out_ch.raised, out_ch.thermal_cap);
				end else begin
					want = profile_due.pop_front();
					if (out_ch.profile !== want.profile || out_ch.changed !== want.changed ||
							out_ch.raised !== want.raised || out_ch.thermal_cap !== want.hot) begin
						fail_count++;
						if (fail_count <= 10)
							$display("decision %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								results_seen, want.profile, want.changed, want.raised, want.hot,
								out_ch.profile, out_ch.changed, out_ch.raised,
								out_ch.thermal_cap);
					end
				end
			end
			// idle rate changes every stretch, some stretches never stall
			if (stretch == 0) begin
				stretch = 200;
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 20;
					default: idle_pct = 50;
				endcase
			end
			stretch--;
			// one long hold-off so the governor backs up into its input
			if (!held_off && results_seen >= 150) begin
				held_off = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left = gap_len() - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// run limit
	initial begin : watchdog
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
